// File: rtl/btty_pkg.sv
// btty_pkg: item types, register indexes, framed code constants and the
// character-to-baudot mapping tables for the baudot tty encoder.
// No dependencies.
package btty_pkg;

  typedef struct packed {
    logic       op;
    logic [7:0] char_code;
  } char_item_t;

  typedef struct packed {
    logic [7:0] tx_code;
    logic       last;
  } code_item_t;

  localparam logic OP_CHAR = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic REG_STANDARD      = 1'b0;
  localparam logic REG_PAUSE_TIMEOUT = 1'b1;

  localparam logic [7:0] PAUSE_TIMEOUT_RESET = 8'd2;

  localparam logic [7:0] MODE_RESEND_COUNT = 8'd72;
  localparam logic [6:0] CR_MIN_COUNT      = 7'd60;
  localparam logic [6:0] CR_MAX_COUNT      = 7'd72;

  localparam logic [7:0] TX_LETTERS = 8'hFE;
  localparam logic [7:0] TX_FIGURES = 8'hF6;
  localparam logic [7:0] TX_CARRIER = 8'hFF;
  localparam logic [7:0] TX_CR      = 8'hD0;
  localparam logic [7:0] TX_FRAME   = 8'hC0;

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;

  // mapped code: bit 6 letters set, bit 5 figures set, bits 4:0 baudot code
  localparam int unsigned BUF_DEPTH = 5;

  localparam logic [4:0] ALPHA_CODES [0:31] = '{
    5'h00, 5'h03, 5'h19, 5'h0E, 5'h09, 5'h01, 5'h0D, 5'h1A,
    5'h14, 5'h06, 5'h0B, 5'h0F, 5'h12, 5'h1C, 5'h0C, 5'h18,
    5'h16, 5'h17, 5'h0A, 5'h05, 5'h10, 5'h07, 5'h1E, 5'h13,
    5'h1D, 5'h15, 5'h11, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00
  };

  localparam logic [6:0] PUNCT_US [0:31] = '{
    7'h64, 7'h2D, 7'h31, 7'h00, 7'h29, 7'h00, 7'h00, 7'h2B,
    7'h2F, 7'h32, 7'h00, 7'h3A, 7'h2C, 7'h23, 7'h3C, 7'h3D,
    7'h36, 7'h37, 7'h33, 7'h21, 7'h2A, 7'h30, 7'h35, 7'h27,
    7'h26, 7'h38, 7'h2E, 7'h3E, 7'h00, 7'h34, 7'h00, 7'h39
  };

  localparam logic [6:0] PUNCT_EU [0:31] = '{
    7'h64, 7'h2D, 7'h00, 7'h00, 7'h00, 7'h00, 7'h3A, 7'h25,
    7'h2F, 7'h32, 7'h00, 7'h31, 7'h2C, 7'h23, 7'h3C, 7'h3D,
    7'h36, 7'h37, 7'h33, 7'h21, 7'h2A, 7'h30, 7'h35, 7'h27,
    7'h26, 7'h38, 7'h2E, 7'h00, 7'h00, 7'h3E, 7'h00, 7'h39
  };

  // zero means the character has no baudot code
  function automatic logic [6:0] map_char(input logic [7:0] c, input logic eu);
    logic [6:0] r;
    r = 7'h00;
    if ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A)) begin
      r = {2'b10, ALPHA_CODES[c[4:0]]};
    end else if (c[7:5] == 3'b001) begin
      r = eu ? PUNCT_EU[c[4:0]] : PUNCT_US[c[4:0]];
    end else begin
      case (c)
        8'h05:   r = eu ? 7'h29 : 7'h00;
        8'h07:   r = eu ? 7'h2B : 7'h25;
        8'h08:   r = 7'h60;
        8'h0A:   r = 7'h62;
        8'h0D:   r = 7'h68;
        8'h9C:   r = eu ? 7'h34 : 7'h00;
        default: r = 7'h00;
      endcase
    end
    return r;
  endfunction

endpackage

// File: rtl/baudot_tty_char_encoder_core.sv
// baudot_tty_char_encoder_core: maps characters to framed baudot code items,
// with carrier, shift, mode resend and carriage return insertion.
// Depends on btty_pkg.
// The first code item passes stage 1, then the output buffer once it is free.
// Throughput: one character item per cycle when each gives one code item and
// code_stall is low; else stage 1 holds it until the buffer (up to 5 code items,
// drained one a cycle unless stalled) empties. Ticks and unmapped chars do not wait.
// Reset (synchronous, rst high): state entry reads as its reset value until
// first written, config back to us table and a pause timeout of 2.
module baudot_tty_char_encoder_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                char_valid,
  output logic                char_stall,
  input  btty_pkg::char_item_t char_item,
  output logic                code_valid,
  input  logic                code_stall,
  output btty_pkg::code_item_t code_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_index,
  input  logic [7:0]          cfg_data
);
  import btty_pkg::*;

  typedef struct packed {
    logic       lts;
    logic       fig;
    logic [7:0] csm;
    logic [6:0] csn;
    logic [7:0] idle;
  } st_t;

  localparam st_t ST_RESET = '{lts: 1'b0, fig: 1'b0, csm: 8'd0, csn: 7'd0, idle: 8'd0};

  // config
  logic       standard;
  logic [7:0] pause_timeout;

  // single-entry state memory, read on accept, written back from stage 1
  st_t  state_mem [0:0];
  logic state_init;
  st_t  rd_data;
  logic rd_init;
  logic fwd;
  st_t  fwd_data;

  // stage 1
  logic       s1_valid;
  logic       s1_op;
  logic [7:0] s1_char;
  logic [6:0] s1_code;
  logic       s1_done;
  logic       s1_wr;
  logic       s1_load;
  st_t        cur;
  st_t        state_next;

  // output buffer
  logic [7:0] obuf [0:BUF_DEPTH-1];
  logic [2:0] ocnt;
  logic [2:0] oidx;
  logic       ovalid;
  logic       taken;
  logic       buf_free;

  logic [7:0] obuf_next [0:BUF_DEPTH-1];
  logic [2:0] ocnt_next;

  logic accept;
  logic timed;
  logic in_ltr;
  logic in_fig;
  logic newline;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      standard      <= 1'b0;
      pause_timeout <= PAUSE_TIMEOUT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_STANDARD:      standard      <= cfg_data[0];
        REG_PAUSE_TIMEOUT: pause_timeout <= cfg_data;
        default:           ;
      endcase
    end
  end

  assign taken    = ovalid & ~code_stall;
  assign buf_free = ~ovalid | (taken & (oidx == ocnt - 3'd1));
  assign s1_done  = (s1_op == OP_TICK) | (s1_code == 7'd0) | buf_free;
  assign s1_wr    = s1_valid & s1_done & ((s1_op == OP_TICK) | (s1_code != 7'd0));
  assign s1_load  = s1_valid & (s1_op == OP_CHAR) & (s1_code != 7'd0) & buf_free;

  assign char_stall = s1_valid & ~s1_done;
  assign accept     = char_valid & ~char_stall;

  // memory port and forwarding of a write landing on the read edge
  always_ff @(posedge clk) begin
    if (s1_wr) begin
      state_mem[0] <= state_next;
    end
    if (accept) begin
      rd_data  <= state_mem[0];
      fwd_data <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state_init <= 1'b0;
      rd_init    <= 1'b0;
      fwd        <= 1'b0;
    end else begin
      if (s1_wr) begin
        state_init <= 1'b1;
      end
      if (accept) begin
        rd_init <= state_init;
        fwd     <= s1_wr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_done) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op   <= char_item.op;
      s1_char <= char_item.char_code;
      s1_code <= map_char(char_item.char_code, standard);
    end
  end

  always_comb begin
    if (fwd) begin
      cur = fwd_data;
    end else if (rd_init) begin
      cur = rd_data;
    end else begin
      cur = ST_RESET;
    end
  end

  always_comb begin
    state_next = cur;
    ocnt_next  = 3'd0;
    timed      = ~cur.lts | (cur.idle >= pause_timeout);
    in_ltr     = s1_code[6];
    in_fig     = s1_code[5];
    newline    = (s1_char == CHAR_CR) | (s1_char == CHAR_LF);
    for (int i = 0; i < BUF_DEPTH; i++) begin
      obuf_next[i] = TX_CARRIER;
    end
    if (s1_op == OP_TICK) begin
      if (cur.idle != 8'hFF) begin
        state_next.idle = cur.idle + 8'd1;
      end
    end else begin
      if (timed) begin
        obuf_next[ocnt_next]         = TX_CARRIER;
        obuf_next[ocnt_next + 3'd1]  = TX_LETTERS;
        ocnt_next                    = ocnt_next + 3'd2;
        state_next.fig               = 1'b0;
        state_next.csm               = 8'd0;
        state_next.lts               = 1'b1;
      end
      priority if (~state_next.fig & ~in_ltr & in_fig) begin
        obuf_next[ocnt_next] = TX_FIGURES;
        ocnt_next            = ocnt_next + 3'd1;
        state_next.fig       = 1'b1;
        state_next.csm       = 8'd0;
      end else if (state_next.fig & ~in_fig & in_ltr) begin
        obuf_next[ocnt_next] = TX_LETTERS;
        ocnt_next            = ocnt_next + 3'd1;
        state_next.fig       = 1'b0;
        state_next.csm       = 8'd0;
      end else if (state_next.csm == MODE_RESEND_COUNT) begin
        obuf_next[ocnt_next] = state_next.fig ? TX_FIGURES : TX_LETTERS;
        ocnt_next            = ocnt_next + 3'd1;
        state_next.csm       = 8'd0;
      end else begin
      end
      if (~newline && (((cur.csn >= CR_MIN_COUNT) && (s1_char == CHAR_SPACE)) ||
                       (cur.csn == CR_MAX_COUNT))) begin
        obuf_next[ocnt_next] = TX_CR;
        ocnt_next            = ocnt_next + 3'd1;
        state_next.csm       = state_next.csm + 8'd1;
        state_next.csn       = 7'd0;
      end
      obuf_next[ocnt_next] = {2'b00, s1_code[4:0], 1'b0} | TX_FRAME;
      ocnt_next            = ocnt_next + 3'd1;
      state_next.csm       = state_next.csm + 8'd1;
      state_next.csn       = newline ? 7'd0 : state_next.csn + 7'd1;
      state_next.idle      = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      for (int i = 0; i < BUF_DEPTH; i++) begin
        obuf[i] <= obuf_next[i];
      end
      ocnt <= ocnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
      oidx   <= 3'd0;
    end else if (s1_load) begin
      ovalid <= 1'b1;
      oidx   <= 3'd0;
    end else if (taken) begin
      if (oidx == ocnt - 3'd1) begin
        ovalid <= 1'b0;
      end else begin
        oidx <= oidx + 3'd1;
      end
    end
  end

  assign code_valid        = ovalid;
  assign code_item.tx_code = obuf[oidx];
  assign code_item.last    = (oidx == ocnt - 3'd1);

endmodule
